FILE: rtl/core/smae_pkg.sv
`default_nettype none

package smae_pkg;

   // Fixed field widths
   localparam int DATA_W     = 32;
   localparam int ACC_W      = 48;
   localparam int FRAC_W     = 16;
   localparam int DIM_W      = 4;
   localparam int IDX_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int RESULT_CAP = 64;
   localparam int RES_CNT_W  = 7;

   // Operation modes
   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_HADAMARD = 2'd1,
      OP_MATMUL   = 2'd2,
      OP_SCALE    = 2'd3
   } op_mode_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LEN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_B       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR = 3'd4;

   typedef struct packed {
      logic                     to_second;
      logic signed [DATA_W-1:0] elem_value;
      logic                     load_done;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [IDX_W-1:0]         result_row;
      logic [IDX_W-1:0]         result_col;
      logic                     saturated;
      logic                     last_result;
   } rsp_type;

   // One operand pair issued to the multiply-accumulate unit
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_issue_type;

   // Finished sum, clipped to the result width
   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [DATA_W-1:0] value;
   } mac_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/small_matrix_arith_engine_top.sv
// Channel   Ports                                   Direction  Moves
// req       req_valid, req_ready, req_data          in         one matrix element
// rsp       rsp_valid, rsp_ready, rsp_data          out        one result element
// csr       csr_we, csr_index, csr_wdata            in         register write, no wait
//
// A loaded element is taken with no wait while loading. An element with load_done
// starts a run that holds req_ready low; for each result the shared
// multiply-accumulate pipeline issues K terms, K being row_len in matmul mode
// and 1 otherwise, then reads, multiplies and accumulates them and loads the
// output register. A stalled rsp channel holds the run at the output register.
// Reset is synchronous; no clearing pass is needed.
`default_nettype none

module small_matrix_arith_engine_top import smae_pkg::*; #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]     csr_wdata
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_FINISH
   } state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > hi) begin
         r = DIM_W'(hi);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Configuration registers
   op_mode_type              op_mode_ff;
   logic [DIM_W-1:0]         rows_a_ff;
   logic [DIM_W-1:0]         row_len_ff;
   logic [DIM_W-1:0]         rows_b_ff;
   logic signed [DATA_W-1:0] scale_ff;

   // Sequencer state
   state_type                state_ff, state_in;
   logic [CW-1:0]            count_a_ff, count_a_in;
   logic [CW-1:0]            count_b_ff, count_b_in;
   logic [DIM_W-1:0]         i_ff, i_in;
   logic [DIM_W-1:0]         j_ff, j_in;
   logic [DIM_W-1:0]         kk_ff, kk_in;
   logic [AW-1:0]            base_a_ff, base_a_in;
   logic [AW-1:0]            base_b_ff, base_b_in;
   logic [DIM_W-1:0]         rl_ff, rl_in;
   logic [DIM_W-1:0]         nc_ff, nc_in;
   logic [RES_CNT_W-1:0]     n_ff, n_in;
   logic [RES_CNT_W-1:0]     total_ff, total_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     matmul;
   logic                     issue_last;
   logic                     emit;
   logic                     run_final;
   logic [DIM_W-1:0]         ra_start;
   logic [DIM_W-1:0]         rl_start;
   logic [DIM_W-1:0]         nc_start;
   logic [2*DIM_W-1:0]       total_prod;
   logic                     we_a, we_b;
   logic [AW-1:0]            a_addr, b_addr;
   logic [DATA_W-1:0]        a_rd_data, b_rd_data;
   mac_issue_type            issue;
   mac_status_type           mac_status;

   // Decode register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff <= OP_ADD;
         rows_a_ff  <= DIM_W'(1);
         row_len_ff <= DIM_W'(1);
         rows_b_ff  <= DIM_W'(1);
         scale_ff   <= DATA_W'(65536);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OP_MODE:      op_mode_ff <= op_mode_type'(csr_wdata[1:0]);
            CSR_ROWS_A:       rows_a_ff  <= csr_wdata[DIM_W-1:0];
            CSR_ROW_LEN:      row_len_ff <= csr_wdata[DIM_W-1:0];
            CSR_ROWS_B:       rows_b_ff  <= csr_wdata[DIM_W-1:0];
            CSR_SCALE_FACTOR: scale_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign matmul    = (op_mode_ff == OP_MATMUL);
   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;

   // Store loads while the store has room
   assign we_a = accept && !req_data.to_second && (int'(count_a_ff) < DEPTH);
   assign we_b = accept && req_data.to_second && (int'(count_b_ff) < DEPTH);

   // Run shape, taken when the final element arrives
   always_comb begin
      ra_start   = clamp_dim(rows_a_ff, MAX_ROWS);
      rl_start   = clamp_dim(row_len_ff, MAX_COLS);
      nc_start   = matmul ? clamp_dim(rows_b_ff, MAX_ROWS) : rl_start;
      total_prod = (2*DIM_W)'(ra_start) * (2*DIM_W)'(nc_start);
   end

   // Operand addresses for the current term
   always_comb begin
      a_addr = base_a_ff + (matmul ? AW'(kk_ff) : AW'(j_ff));
      b_addr = matmul ? (base_b_ff + AW'(kk_ff)) : a_addr;
   end

   assign issue_last  = matmul ? (kk_ff == rl_ff - DIM_W'(1)) : 1'b1;
   assign issue.valid = (state_ff == ST_ISSUE);
   assign issue.first = (kk_ff == '0);
   assign issue.last  = issue_last;

   assign run_final = ((n_ff + RES_CNT_W'(1)) == total_ff);
   assign emit      = (state_ff == ST_FINISH) && mac_status.done &&
                      (!rsp_valid_ff || rsp_ready);

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      kk_in        = kk_ff;
      base_a_in    = base_a_ff;
      base_b_in    = base_b_ff;
      rl_in        = rl_ff;
      nc_in        = nc_ff;
      n_in         = n_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (we_a) begin
               count_a_in = count_a_ff + CW'(1);
            end
            if (we_b) begin
               count_b_in = count_b_ff + CW'(1);
            end
            if (accept && req_data.load_done) begin
               count_a_in = '0;
               count_b_in = '0;
               i_in       = '0;
               j_in       = '0;
               kk_in      = '0;
               base_a_in  = '0;
               base_b_in  = '0;
               n_in       = '0;
               rl_in      = rl_start;
               nc_in      = nc_start;
               total_in   = (total_prod > (2*DIM_W)'(RESULT_CAP)) ?
                            RES_CNT_W'(RESULT_CAP) : total_prod[RES_CNT_W-1:0];
               state_in   = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (issue_last) begin
               kk_in    = '0;
               state_in = ST_FINISH;
            end else begin
               kk_in = kk_ff + DIM_W'(1);
            end
         end
         ST_FINISH: begin
            if (emit) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_value = mac_status.value;
               rsp_data_in.result_row   = i_ff[IDX_W-1:0];
               rsp_data_in.result_col   = j_ff[IDX_W-1:0];
               rsp_data_in.saturated    = mac_status.sat;
               rsp_data_in.last_result  = run_final;
               n_in                     = n_ff + RES_CNT_W'(1);
               if (j_ff == nc_ff - DIM_W'(1)) begin
                  j_in      = '0;
                  i_in      = i_ff + DIM_W'(1);
                  base_a_in = base_a_ff + AW'(rl_ff);
                  base_b_in = '0;
               end else begin
                  j_in      = j_ff + DIM_W'(1);
                  base_b_in = base_b_ff + AW'(rl_ff);
               end
               state_in = run_final ? ST_LOAD : ST_ISSUE;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Hold sequencer state and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      kk_ff       <= kk_in;
      base_a_ff   <= base_a_in;
      base_b_ff   <= base_b_in;
      rl_ff       <= rl_in;
      nc_ff       <= nc_in;
      n_ff        <= n_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   smae_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (we_a),
      .wr_addr (count_a_ff[AW-1:0]),
      .wr_data (req_data.elem_value),
      .rd_en   (issue.valid),
      .rd_addr (a_addr),
      .rd_data (a_rd_data)
   );

   smae_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (we_b),
      .wr_addr (count_b_ff[AW-1:0]),
      .wr_data (req_data.elem_value),
      .rd_en   (issue.valid),
      .rd_addr (b_addr),
      .rd_data (b_rd_data)
   );

   smae_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .mode   (op_mode_ff),
      .a_data (a_rd_data),
      .b_data (b_rd_data),
      .scale  (scale_ff),
      .clear  (emit),
      .status (mac_status)
   );

`ifndef ASSERT_OFF
   a_final_returns_to_load: assert property (@(posedge clock) disable iff (reset)
      (emit && run_final) |=> (state_ff == ST_LOAD))
      else $error("run did not end after its last result");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> ((int'(a_addr) < DEPTH) && (int'(b_addr) < DEPTH)))
      else $error("operand address beyond the store");

   a_counts_clear_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> ((count_a_ff == '0) && (count_b_ff == '0)))
      else $error("load counts not cleared during a run");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/smae_ram.sv
`default_nettype none

module smae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/smae_mac.sv
`default_nettype none

module smae_mac import smae_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mac_issue_type            issue,
   input  wire op_mode_type              mode,
   input  wire logic signed [DATA_W-1:0] a_data,
   input  wire logic signed [DATA_W-1:0] b_data,
   input  wire logic signed [DATA_W-1:0] scale,
   input  wire logic                     clear,
   output mac_status_type                status
);

   mac_issue_type             rd_ctl_ff;
   mac_issue_type             term_ctl_ff;
   logic signed [ACC_W-1:0]   term_ff;
   logic signed [ACC_W-1:0]   term_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic                      done_ff;
   logic                      done_in;
   logic signed [DATA_W-1:0]  opnd;
   logic signed [2*DATA_W-1:0] prod;
   logic signed [ACC_W:0]     sum;
   logic                      clip;

   // Multiply stage: product floored by the fraction shift, or a plain sum in add mode
   always_comb begin
      opnd = (mode == OP_SCALE) ? scale : b_data;
      prod = a_data * opnd;
      if (mode == OP_ADD) begin
         term_in = ACC_W'(a_data) + ACC_W'(b_data);
      end else begin
         term_in = prod[2*DATA_W-1:FRAC_W];
      end
   end

   // Accumulate stage: saturate at the accumulator bounds
   always_comb begin
      sum     = {acc_ff[ACC_W-1], acc_ff} + {term_ff[ACC_W-1], term_ff};
      acc_in  = acc_ff;
      done_in = done_ff;
      if (term_ctl_ff.valid) begin
         if (term_ctl_ff.first) begin
            acc_in = term_ff;
         end else if (sum[ACC_W] != sum[ACC_W-1]) begin
            acc_in = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
         end else begin
            acc_in = sum[ACC_W-1:0];
         end
         if (term_ctl_ff.last) begin
            done_in = 1'b1;
         end
      end
      if (clear) begin
         done_in = 1'b0;
      end
   end

   // Advance the control tags alongside the memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctl_ff   <= '0;
         term_ctl_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         rd_ctl_ff   <= issue;
         term_ctl_ff <= rd_ctl_ff;
         done_ff     <= done_in;
      end
   end

   // Hold the datapath values
   always_ff @(posedge clock) begin
      if (rd_ctl_ff.valid) begin
         term_ff <= term_in;
      end
      acc_ff <= acc_in;
   end

   // Clip the finished sum to the result width
   always_comb begin
      clip          = (acc_ff[ACC_W-1:DATA_W-1] != '0) && (acc_ff[ACC_W-1:DATA_W-1] != '1);
      status.done   = done_ff;
      status.sat    = clip;
      if (!clip) begin
         status.value = acc_ff[DATA_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         status.value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         status.value = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

`ifndef ASSERT_OFF
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(term_ctl_ff.valid && term_ctl_ff.last))
      else $error("sum finished without a last term");

   a_no_issue_while_done: assert property (@(posedge clock) disable iff (reset)
      issue.valid |-> !done_ff)
      else $error("operands issued while a finished sum waits");

   a_clear_only_done: assert property (@(posedge clock) disable iff (reset)
      clear |-> done_ff)
      else $error("sum taken before it was finished");
`endif

endmodule

`default_nettype wire
